// ===== src/fixed_prefix_code_decoder_macros.svh =====
// Assertion helpers for the prefix code decoder.
`ifndef FIXED_PREFIX_CODE_DECODER_MACROS_SVH
`define FIXED_PREFIX_CODE_DECODER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define FPCD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FPCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/fpcd_pkg.sv =====
`default_nettype none
package fpcd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       field_start;
    logic [2:0] pad_bits;
    logic       last_byte;
  } fpcd_in_t;

  typedef struct packed {
    logic [6:0] symbol;
    logic       is_symbol;
    logic       end_of_field;
    logic       cut_short;
  } fpcd_out_t;

  typedef struct packed {
    logic       leaf;
    logic [3:0] node;
    logic [6:0] sym;
  } fpcd_step_t;

  localparam int unsigned MaxResults = 3;

  // Internal nodes of the code tree, named by the path from the root.
  localparam logic [3:0] ND_ROOT   = 4'd0;
  localparam logic [3:0] ND_0      = 4'd1;
  localparam logic [3:0] ND_1      = 4'd2;
  localparam logic [3:0] ND_00     = 4'd3;
  localparam logic [3:0] ND_01     = 4'd4;
  localparam logic [3:0] ND_10     = 4'd5;
  localparam logic [3:0] ND_11     = 4'd6;
  localparam logic [3:0] ND_011    = 4'd7;
  localparam logic [3:0] ND_110    = 4'd8;
  localparam logic [3:0] ND_111    = 4'd9;
  localparam logic [3:0] ND_0111   = 4'd10;
  localparam logic [3:0] ND_1110   = 4'd11;
  localparam logic [3:0] ND_01111  = 4'd12;
  localparam logic [3:0] ND_011110 = 4'd13;

  // ASCII codes of the symbols
  localparam logic [6:0] CH_0     = 7'h30;
  localparam logic [6:0] CH_1     = 7'h31;
  localparam logic [6:0] CH_2     = 7'h32;
  localparam logic [6:0] CH_3     = 7'h33;
  localparam logic [6:0] CH_4     = 7'h34;
  localparam logic [6:0] CH_5     = 7'h35;
  localparam logic [6:0] CH_6     = 7'h36;
  localparam logic [6:0] CH_7     = 7'h37;
  localparam logic [6:0] CH_8     = 7'h38;
  localparam logic [6:0] CH_9     = 7'h39;
  localparam logic [6:0] CH_LPAR  = 7'h28;
  localparam logic [6:0] CH_RPAR  = 7'h29;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_A     = 7'h61;
  localparam logic [6:0] CH_NONE  = 7'h00;

  function automatic fpcd_step_t fpcd_leaf(input logic [6:0] s);
    fpcd_step_t r;
    r.leaf = 1'b1;
    r.node = ND_ROOT;
    r.sym  = s;
    return r;
  endfunction

  function automatic fpcd_step_t fpcd_inner(input logic [3:0] n);
    fpcd_step_t r;
    r.leaf = 1'b0;
    r.node = n;
    r.sym  = CH_NONE;
    return r;
  endfunction

  // One edge of the code tree. Unused node codes behave as the root.
  function automatic fpcd_step_t fpcd_step(input logic [3:0] node, input logic b);
    fpcd_step_t r;
    case (node)
      ND_0:      r = b ? fpcd_inner(ND_01)    : fpcd_inner(ND_00);
      ND_1:      r = b ? fpcd_inner(ND_11)    : fpcd_inner(ND_10);
      ND_00:     r = b ? fpcd_leaf(CH_1)      : fpcd_leaf(CH_2);
      ND_01:     r = b ? fpcd_inner(ND_011)   : fpcd_leaf(CH_PLUS);
      ND_10:     r = b ? fpcd_leaf(CH_A)      : fpcd_leaf(CH_STAR);
      ND_11:     r = b ? fpcd_inner(ND_111)   : fpcd_inner(ND_110);
      ND_011:    r = b ? fpcd_inner(ND_0111)  : fpcd_leaf(CH_6);
      ND_110:    r = b ? fpcd_leaf(CH_4)      : fpcd_leaf(CH_5);
      ND_111:    r = b ? fpcd_leaf(CH_3)      : fpcd_inner(ND_1110);
      ND_0111:   r = b ? fpcd_inner(ND_01111) : fpcd_leaf(CH_9);
      ND_1110:   r = b ? fpcd_leaf(CH_8)      : fpcd_leaf(CH_7);
      ND_01111:  r = b ? fpcd_leaf(CH_0)      : fpcd_inner(ND_011110);
      ND_011110: r = b ? fpcd_leaf(CH_RPAR)   : fpcd_leaf(CH_LPAR);
      default:   r = b ? fpcd_inner(ND_1)     : fpcd_inner(ND_0);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== src/fixed_prefix_code_decoder.sv =====
// Fixed prefix code decoder: takes a bit-packed field one byte per request,
// MSB first, with leading pad bits skipped on the field's first byte, and
// returns one result request per decoded ASCII symbol (digits, ( ) + * a).
// The final byte's last result carries end_of_field, and cut_short when the
// field stopped inside a code; a final byte that completes no code gives a
// lone result with is_symbol low. A byte is registered on entry, walked
// through the code tree combinationally (all eight bits), and its up to
// three results land in a small result buffer that drains one per cycle
// while out_ready is high; a result passes the input register, then the buffer.
// A byte that yields zero or one result is taken every cycle while out_ready
// is high; one with more holds the input, so the output port sets throughput.
`default_nettype none
module fixed_prefix_code_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpcd_pkg::fpcd_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpcd_pkg::fpcd_out_t     out_data
);
  import fpcd_pkg::*;
  `include "fixed_prefix_code_decoder_macros.svh"

  // input register
  logic       in_v_r, in_v_nxt;
  fpcd_in_t   in_r;

  // code tree position carried across bytes
  logic [3:0] tree_pos_r, tree_pos_nxt;

  // result buffer; entry 0 is at the output
  fpcd_out_t  res_r [MaxResults];
  logic [1:0] cnt_r, cnt_nxt;

  // one-pass decode of the registered byte
  fpcd_out_t  res_w [MaxResults];
  logic [1:0] cnt_w;
  logic [3:0] pos_end_w;

  logic       buf_free;
  logic       load;
  logic       out_take;

  assign out_take  = out_valid && out_ready;
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign load      = in_v_r && buf_free;
  assign in_ready  = !in_v_r || load;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = res_r[0];

  // Tree walk: eight dependent steps on a 4-bit node.
  always_comb begin
    logic [3:0] pos;
    logic [2:0] first;
    fpcd_step_t st;
    logic       cut;
    pos   = (in_r.field_start || tree_pos_r > ND_011110) ? ND_ROOT : tree_pos_r;
    first = in_r.field_start ? in_r.pad_bits : 3'd0;
    cnt_w = 2'd0;
    cut   = 1'b0;
    st    = '0;
    for (int k = 0; k < MaxResults; k++) begin
      res_w[k] = '0;
    end
    for (int i = 0; i < 8; i++) begin
      if (3'(i) >= first) begin
        st = fpcd_step(pos, in_r.data_byte[3'(7 - i)]);
        if (st.leaf) begin
          if (cnt_w != 2'd3) begin
            res_w[cnt_w].symbol    = st.sym;
            res_w[cnt_w].is_symbol = 1'b1;
            cnt_w                  = cnt_w + 2'd1;
          end
          pos = ND_ROOT;
        end else begin
          pos = st.node;
        end
      end
    end
    if (in_r.last_byte) begin
      cut = (pos != ND_ROOT);
      if (cnt_w == 2'd0) begin
        res_w[0].end_of_field = 1'b1;
        res_w[0].cut_short    = cut;
        cnt_w                 = 2'd1;
      end else begin
        res_w[cnt_w - 2'd1].end_of_field = 1'b1;
        res_w[cnt_w - 2'd1].cut_short    = cut;
      end
      pos = ND_ROOT;
    end
    pos_end_w = pos;
  end

  always_comb begin
    in_v_nxt     = in_v_r;
    cnt_nxt      = cnt_r;
    tree_pos_nxt = tree_pos_r;
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end else if (load) begin
      in_v_nxt = 1'b0;
    end
    if (load) begin
      cnt_nxt      = cnt_w;
      tree_pos_nxt = pos_end_w;
    end else if (out_take) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r     <= 1'b0;
      cnt_r      <= 2'd0;
      tree_pos_r <= ND_ROOT;
    end else begin
      in_v_r     <= in_v_nxt;
      cnt_r      <= cnt_nxt;
      tree_pos_r <= tree_pos_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (load) begin
      for (int k = 0; k < MaxResults; k++) begin
        res_r[k] <= res_w[k];
      end
    end else if (out_take) begin
      for (int k = 0; k < MaxResults - 1; k++) begin
        res_r[k] <= res_r[k + 1];
      end
    end
  end

  `FPCD_ASSERT_NEXT(a_last_to_root, load && in_r.last_byte, tree_pos_r == ND_ROOT,
    "tree position not at root after final byte")
  `FPCD_ASSERT_NEXT(a_last_has_result, load && in_r.last_byte, cnt_r != 2'd0,
    "final byte produced no result")
  `FPCD_ASSERT_NOW(a_eof_is_final, out_valid && out_data.end_of_field, cnt_r == 2'd1,
    "end of field not on last buffered result")
  `FPCD_ASSERT_NOW(a_cut_needs_eof, out_valid && out_data.cut_short, out_data.end_of_field,
    "cut_short without end_of_field")

endmodule
`default_nettype wire

// ===== bench/tb_fixed_prefix_code_decoder.sv =====
`default_nettype none
module tb_fixed_prefix_code_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import fpcd_pkg::*;

  // Results one input byte can give (codes are 3 bits or longer), with the
  // count of valid entries; res[0] comes out first.
  typedef struct packed {
    logic [1:0]           count;
    fpcd_out_t [2:0]      res;
  } decode_t;

  // One input request plus, for directed rows, the results typed in by hand.
  typedef struct packed {
    fpcd_in_t req;
    logic     typed;
    decode_t  want;
  } req_row_t;

  localparam int NumReqs     = 330;
  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 80;    // long receiver hold-off
  localparam int BurstReqs   = 30;    // back-to-back requests during the hold
  localparam int DrainCycles = 16;    // quiet time after the last result

  // Code tree, two children per internal node, indexed by {node, bit}.
  // Bit 7 set marks a leaf holding the ASCII symbol in bits 6:0.
  localparam logic [0:27][7:0] CODE_KIDS = {
    {4'h0, ND_0},      {4'h0, ND_1},       // root
    {4'h0, ND_00},     {4'h0, ND_01},      // 0
    {4'h0, ND_10},     {4'h0, ND_11},      // 1
    {1'b1, CH_2},      {1'b1, CH_1},       // 00
    {1'b1, CH_PLUS},   {4'h0, ND_011},     // 01
    {1'b1, CH_STAR},   {1'b1, CH_A},       // 10
    {4'h0, ND_110},    {4'h0, ND_111},     // 11
    {1'b1, CH_6},      {4'h0, ND_0111},    // 011
    {1'b1, CH_5},      {1'b1, CH_4},       // 110
    {4'h0, ND_1110},   {1'b1, CH_3},       // 111
    {1'b1, CH_9},      {4'h0, ND_01111},   // 0111
    {1'b1, CH_7},      {1'b1, CH_8},       // 1110
    {4'h0, ND_011110}, {1'b1, CH_0},       // 01111
    {1'b1, CH_LPAR},   {1'b1, CH_RPAR}     // 011110
  };

  // Encoder side for well-formed fields: {length, code right-aligned}.
  localparam logic [0:14][9:0] CODE_BOOK = {
    {3'd3, 7'b0000000},  // '2'
    {3'd3, 7'b0000001},  // '1'
    {3'd3, 7'b0000010},  // '+'
    {3'd4, 7'b0000110},  // '6'
    {3'd5, 7'b0001110},  // '9'
    {3'd6, 7'b0011111},  // '0'
    {3'd7, 7'b0111100},  // '('
    {3'd7, 7'b0111101},  // ')'
    {3'd3, 7'b0000100},  // '*'
    {3'd3, 7'b0000101},  // 'a'
    {3'd4, 7'b0001100},  // '5'
    {3'd4, 7'b0001101},  // '4'
    {3'd4, 7'b0001111},  // '3'
    {3'd5, 7'b0011100},  // '7'
    {3'd5, 7'b0011101}   // '8'
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  fpcd_in_t  in_data;
  logic      out_valid;
  logic      out_ready;
  fpcd_out_t out_data;

  fixed_prefix_code_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Decoder state mirrored on the bench side, plus bookkeeping.
  logic [3:0] tree_pos;
  fpcd_out_t  expected_syms[$];   // results still owed by the block
  req_row_t   offered_reqs[$];    // requests on the input port, not yet taken
  int         mismatches  = 0;
  int         cycles      = 0;
  int         reqs_sent   = 0;
  bit         quiet       = 1'b0; // no idling on either side while set
  bit         hold_req    = 1'b0; // asks the receiver for one long hold-off
  int         burst_left  = 0;    // sender requests to offer with no gap

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic fpcd_out_t out_of(input logic [6:0] ch, input logic is_sym,
                                       input logic eof, input logic cut);
    fpcd_out_t r;
    r.symbol       = ch;
    r.is_symbol    = is_sym;
    r.end_of_field = eof;
    r.cut_short    = cut;
    return r;
  endfunction

  function automatic req_row_t mk_row(input logic [7:0] b, input logic s,
                                      input logic [2:0] p, input logic l,
                                      input logic typed = 1'b0,
                                      input logic [1:0] n = 2'd0,
                                      input fpcd_out_t r0 = '0,
                                      input fpcd_out_t r1 = '0,
                                      input fpcd_out_t r2 = '0);
    req_row_t row;
    row.req.data_byte   = b;
    row.req.field_start = s;
    row.req.pad_bits    = p;
    row.req.last_byte   = l;
    row.typed           = typed;
    row.want.count      = n;
    row.want.res        = {r2, r1, r0};
    return row;
  endfunction

  // Walks one byte through the code tree from the current position and
  // returns the symbols it completes; end of field rides on the last one.
  function automatic decode_t decode_byte(input fpcd_in_t req);
    decode_t         d;
    fpcd_out_t [2:0] found;
    fpcd_out_t       tail;
    logic [3:0]      node;
    logic [7:0]      kid;
    int              first;
    int              n;
    int              i;
    found = '0;
    first = 0;
    n     = 0;
    if (req.field_start) begin
      tree_pos = ND_ROOT;
      first    = int'(req.pad_bits);
    end
    // codes 14 and 15 are not tree nodes: restart from the root
    node = (tree_pos > ND_011110) ? ND_ROOT : tree_pos;
    for (i = first; i < 8; i++) begin
      kid = CODE_KIDS[{node, req.data_byte[7 - i]}];
      if (kid[7]) begin
        found[n] = out_of(kid[6:0], 1'b1, 1'b0, 1'b0);
        n++;
        node = ND_ROOT;
      end else begin
        node = kid[3:0];
      end
    end
    if (req.last_byte) begin
      if (n == 0) begin
        // nothing completed: a bare end marker
        found[0] = out_of(CH_NONE, 1'b0, 1'b1, node != ND_ROOT);
        n = 1;
      end else begin
        tail              = found[n - 1];
        tail.end_of_field = 1'b1;
        tail.cut_short    = (node != ND_ROOT);
        found[n - 1]      = tail;
      end
      node = ND_ROOT;
    end
    tree_pos = node;
    d.count  = n[1:0];
    d.res    = found;
    return d;
  endfunction

  // Puts one request on the input port after a gap (random, or zero when quiet
  // or in a burst) and returns once the block has taken it. Valid stays high
  // into the next request when the next gap is zero.
  task automatic offer(input req_row_t row);
    int gap;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else begin
      gap = quiet ? 0 : $urandom_range(0, 4);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= row.req;
    offered_reqs.push_back(row);
    reqs_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drops valid and waits until every owed result has come out.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_syms.size() != 0) @(posedge clk);
  endtask

  // Port watcher: values read right after the edge are the ones the block
  // saw at that edge. Results are checked before the new request is added,
  // since a request never produces a result at its own accept edge.
  always @(posedge clk) begin : watch_ports
    req_row_t  row;
    decode_t   got;
    fpcd_out_t want;
    int        k;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_syms.size() == 0) begin
          $error("unexpected result: symbol %h is_symbol %b eof %b cut %b",
                 out_data.symbol, out_data.is_symbol, out_data.end_of_field,
                 out_data.cut_short);
          mismatches++;
        end else begin
          want = expected_syms.pop_front();
          if (out_data.symbol !== want.symbol) begin
            $error("symbol: expected %h, got %h", want.symbol, out_data.symbol);
            mismatches++;
          end
          if (out_data.is_symbol !== want.is_symbol) begin
            $error("is_symbol: expected %b, got %b", want.is_symbol,
                   out_data.is_symbol);
            mismatches++;
          end
          if (out_data.end_of_field !== want.end_of_field) begin
            $error("end_of_field: expected %b, got %b", want.end_of_field,
                   out_data.end_of_field);
            mismatches++;
          end
          if (out_data.cut_short !== want.cut_short) begin
            $error("cut_short: expected %b, got %b", want.cut_short,
                   out_data.cut_short);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        row = offered_reqs.pop_front();
        // always step the mirrored tree; hand-typed rows override the results
        got = decode_byte(row.req);
        if (row.typed) got = row.want;
        for (k = 0; k < got.count; k++) expected_syms.push_back(got.res[k]);
      end
    end
  end

  // Receiver: one random stall per result, with a single long hold-off when
  // asked, counted here so the sender keeps pushing meanwhile.
  initial begin : result_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin : stimulus
    req_row_t   dir_tab[$];
    bit         bits_q[$];
    logic [9:0] code;
    logic [7:0] byte_val;
    logic [2:0] pad_field;
    logic       drop_last;
    bit         held;
    bit         paused;
    int         kind;
    int         nsym;
    int         nbytes;
    int         pad;
    int         extra;
    int         j;
    int         k;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    tree_pos = ND_ROOT;
    held     = 1'b0;
    paused   = 1'b0;

    // Directed rows. Hand-typed results where they are obvious; the rest
    // go through the tree walk.
    // Right after reset: two '2' codes, stops inside a code.
    dir_tab.push_back(mk_row(8'h00, 1'b1, 3'd0, 1'b0, 1'b1, 2'd2,
                             out_of(CH_2, 1'b1, 1'b0, 1'b0),
                             out_of(CH_2, 1'b1, 1'b0, 1'b0)));
    // Continues mid-code, three symbols from one byte, ends cut short;
    // pad bits ignored without a field start.
    dir_tab.push_back(mk_row(8'h00, 1'b0, 3'd7, 1'b1, 1'b1, 2'd3,
                             out_of(CH_2, 1'b1, 1'b0, 1'b0),
                             out_of(CH_2, 1'b1, 1'b0, 1'b0),
                             out_of(CH_2, 1'b1, 1'b1, 1'b1)));
    // Start and last together with max pad: one bit, no symbol, cut short.
    dir_tab.push_back(mk_row(8'hFE, 1'b1, 3'd7, 1'b1, 1'b1, 2'd1,
                             out_of(CH_NONE, 1'b0, 1'b1, 1'b1)));
    dir_tab.push_back(mk_row(8'hFF, 1'b1, 3'd7, 1'b1, 1'b1, 2'd1,
                             out_of(CH_NONE, 1'b0, 1'b1, 1'b1)));
    // Single code field ending cleanly.
    dir_tab.push_back(mk_row(8'h00, 1'b1, 3'd5, 1'b1, 1'b1, 2'd1,
                             out_of(CH_2, 1'b1, 1'b1, 1'b0)));
    dir_tab.push_back(mk_row(8'hFF, 1'b1, 3'd0, 1'b0, 1'b1, 2'd2,
                             out_of(CH_3, 1'b1, 1'b0, 1'b0),
                             out_of(CH_3, 1'b1, 1'b0, 1'b0)));
    dir_tab.push_back(mk_row(8'hFF, 1'b0, 3'd0, 1'b1, 1'b1, 2'd2,
                             out_of(CH_3, 1'b1, 1'b0, 1'b0),
                             out_of(CH_3, 1'b1, 1'b1, 1'b0)));
    // Byte that completes nothing and is not last: no result.
    dir_tab.push_back(mk_row(8'h07, 1'b1, 3'd4, 1'b0, 1'b1, 2'd0));
    dir_tab.push_back(mk_row(8'h80, 1'b0, 3'd3, 1'b1));
    // All fifteen codes in one right-aligned field, 6 pad bits.
    dir_tab.push_back(mk_row(8'h00, 1'b1, 3'd6, 1'b0));
    dir_tab.push_back(mk_row(8'h14, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'hCE, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'h7D, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'hE3, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'hD9, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'h73, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'h7F, 1'b0, 3'd0, 1'b0));
    dir_tab.push_back(mk_row(8'h9D, 1'b0, 3'd0, 1'b1));
    // Decoding carries on after a field end without a new start.
    dir_tab.push_back(mk_row(8'h55, 1'b0, 3'd2, 1'b0));
    dir_tab.push_back(mk_row(8'h00, 1'b1, 3'd0, 1'b1));

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) offer(dir_tab[i]);

    // Random part: mostly well-formed fields built from random symbols,
    // some with stray tail bits or a missing end, some raw noise requests.
    while (reqs_sent < NumReqs) begin
      quiet = ((reqs_sent / 40) % 2) == 1;
      if (!held && reqs_sent >= 150) begin
        held       = 1'b1;
        hold_req   = 1'b1;
        burst_left = BurstReqs;
      end
      if (!paused && reqs_sent >= 260) begin
        paused = 1'b1;
        drain_all();
      end
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        offer(mk_row(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                     3'($urandom_range(0, 7)), 1'($urandom_range(0, 1))));
      end else begin
        bits_q.delete();
        nsym = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20)
                                           : $urandom_range(1, 6);
        repeat (nsym) begin
          code = CODE_BOOK[$urandom_range(0, 14)];
          for (j = int'(code[9:7]) - 1; j >= 0; j--) bits_q.push_back(code[j]);
        end
        drop_last = 1'b0;
        if (kind == 2) begin
          extra = $urandom_range(1, 6);
          repeat (extra) bits_q.push_back(1'($urandom_range(0, 1)));
          drop_last = 1'($urandom_range(0, 1));
        end
        nbytes = (bits_q.size() + 7) / 8;
        pad    = nbytes * 8 - bits_q.size();
        // pad bits carry junk; the block must skip them
        repeat (pad) bits_q.push_front(1'($urandom_range(0, 1)));
        for (k = 0; k < nbytes; k++) begin
          for (j = 0; j < 8; j++) byte_val[7 - j] = bits_q[8 * k + j];
          pad_field = (k == 0) ? 3'(pad) : 3'($urandom_range(0, 7));
          offer(mk_row(byte_val, k == 0, pad_field,
                       (k == nbytes - 1) && !drop_last));
        end
      end
    end

    drain_all();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && expected_syms.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
